FILE: rtl/core/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sha256_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;
  localparam int FillW      = 6;
  localparam int RoundW     = 6;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INITIAL_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Controller to datapath commands.
  typedef struct packed {
    logic       store_byte;  // write in_byte at fill, advance fill and length
    logic       pad_start;   // write 0x80 at fill
    logic       pad_zero;    // write zero at fill
    logic       pad_len;     // write length byte at fill
    logic       round_init;  // load working words from chain
    logic       round_step;  // run one round
    logic       chain_add;   // fold working words into chain
    logic       restart;     // back to the reset state
  } sha256_cmd_t;

  typedef struct packed {
    logic             fill_wrapped; // fill is zero after a store
    logic [FillW-1:0] fill;
    logic             last_round;
  } sha256_sts_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: rtl/core/sha256_datapath.sv
// Schedule window that also buffers the block, round unit, chaining words and length counter.
module sha256_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::sha256_cmd_t cmd,
  input  logic [7:0]             in_byte,
  output sha256_pkg::sha256_sts_t sts,
  output logic [255:0]           digest
);
  import sha256_pkg::*;

  logic [FillW-1:0]  fill;
  logic [63:0]       message_bits;
  logic [31:0]       chain_words [8];
  logic [31:0]       v [8];
  logic [31:0]       w [16];
  logic [RoundW-1:0] round;
  logic [7:0]        wr_byte;
  logic              wr_en;
  logic [2:0]        len_sel;
  logic [1:0]        lane;

  always_comb begin
    len_sel = 3'(~fill[2:0]);
    lane    = ~fill[1:0];
    wr_en   = cmd.store_byte | cmd.pad_start | cmd.pad_zero | cmd.pad_len;
    wr_byte = 8'h00;
    if (cmd.store_byte) wr_byte = in_byte;
    else if (cmd.pad_start) wr_byte = PadByte;
    else if (cmd.pad_len) wr_byte = message_bits[8*len_sel +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      fill <= '0;
      message_bits <= '0;
    end else begin
      if (wr_en) fill <= fill + 1'b1;
      if (cmd.store_byte) message_bits <= message_bits + 64'd8;
    end
  end

  // Schedule: a 16-word window that shifts by one word per round.
  logic [31:0] s0, s1, w_new, t1, t2, sig0, sig1, ch, maj;
  always_comb begin
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    sig1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + sig1 + ch + ROUND_K[round] + w[0];
    sig0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = sig0 + maj;
  end

  // Between compressions the window holds the block bytes, big-endian in each word.
  // Every byte of a block is written before it is compressed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      w[fill[5:2]][8*lane +: 8] <= wr_byte;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_init) begin
      for (int i = 0; i < 8; i++) v[i] <= chain_words[i];
    end else if (cmd.round_step) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.round_init) round <= '0;
    else if (cmd.round_step) round <= round + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) chain_words[i] <= INITIAL_H[i];
    end else if (cmd.chain_add) begin
      for (int i = 0; i < 8; i++) chain_words[i] <= chain_words[i] + v[i];
    end
  end

  assign digest = {chain_words[0], chain_words[1], chain_words[2], chain_words[3],
                   chain_words[4], chain_words[5], chain_words[6], chain_words[7]};
  assign sts.fill = fill;
  assign sts.fill_wrapped = (fill == '0);
  assign sts.last_round = (round == RoundW'(Rounds - 1));
endmodule

FILE: rtl/core/sha256_ctrl.sv
// Sequencer for byte intake, compression rounds, padding and digest hand-off.
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic                    in_valid_byte,
  input  logic                    in_last,
  output logic                    in_ready,
  input  logic                    out_ready,
  output logic                    out_valid,
  input  sha256_pkg::sha256_sts_t sts,
  output sha256_pkg::sha256_cmd_t cmd
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_INIT = 3'd2, S_ROUND = 3'd3,
                         S_ADD = 3'd4, S_PAD = 3'd5, S_OUT = 3'd6;

  logic [2:0] state, state_next;
  logic pad_mode, pad_mode_next;   // finishing a message
  logic pad_begun, pad_begun_next; // the 0x80 byte is written
  logic len_block, len_block_next; // this padded block carries the length
  logic item_last, item_last_next;
  logic byte_stored;               // the word just taken carried a byte

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pad_mode <= 1'b0; pad_begun <= 1'b0;
      len_block <= 1'b0; item_last <= 1'b0;
    end else begin
      state <= state_next; pad_mode <= pad_mode_next; pad_begun <= pad_begun_next;
      len_block <= len_block_next; item_last <= item_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) byte_stored <= 1'b0;
    else if (state == S_IDLE) byte_stored <= in_fire && in_valid_byte;
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state; pad_mode_next = pad_mode; pad_begun_next = pad_begun;
    len_block_next = len_block; item_last_next = item_last;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.store_byte = in_valid_byte;
          item_last_next = in_last;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // A stored byte that fills the block is compressed before anything else.
        if (byte_stored && sts.fill_wrapped) begin
          state_next = S_INIT;
        end else if (item_last) begin
          pad_mode_next = 1'b1; state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PAD: begin
        if (!pad_begun) begin
          cmd.pad_start = 1'b1; pad_begun_next = 1'b1;
          // With the 0x80 byte at 55, the length still fits in this block.
          if (sts.fill == 6'd55) len_block_next = 1'b1;
          if (sts.fill == 6'd63) state_next = S_INIT;
        end else if (sts.fill >= 6'd56 && len_block) begin
          cmd.pad_len = 1'b1;
          if (sts.fill == 6'd63) state_next = S_INIT;
        end else if (sts.fill >= 6'd56 && !len_block && sts.fill != 6'd0) begin
          cmd.pad_zero = 1'b1;
          if (sts.fill == 6'd63) state_next = S_INIT;
        end else begin
          if (sts.fill == 6'd0 && !len_block) len_block_next = 1'b1;
          else cmd.pad_zero = 1'b1;
          if (sts.fill == 6'd55) len_block_next = 1'b1;
        end
      end
      S_INIT: begin
        cmd.round_init = 1'b1; state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (sts.last_round) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        if (!pad_mode) begin
          state_next = item_last ? S_PAD : S_IDLE;
          pad_mode_next = item_last;
        end else if (len_block) state_next = S_OUT;
        else state_next = S_PAD;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.restart = 1'b1; state_next = S_IDLE;
          pad_mode_next = 1'b0; pad_begun_next = 1'b0; len_block_next = 1'b0;
          item_last_next = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input open while digest pending");
  a_round_after_init: assert property (@(posedge clk) disable iff (rst)
    cmd.round_init |=> state == S_ROUND) else $error("rounds did not follow init");
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.restart |=> state == S_IDLE && !pad_mode) else $error("restart failed");
endmodule

FILE: rtl/core/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Bytes enter one word per handshake; each word is checked before the next is
// taken. The 64th byte of a block starts 64 compression rounds on one shared
// round unit, and no input is taken while they run. A last word pads the block
// one byte at a time and runs one or two further compressions before the digest
// appears on the output; the next message is taken once the digest word is accepted.
module sha256_byte_stream_hasher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // data_byte
  input  logic         s_axis_tlast,  // last
  input  logic         s_axis_tuser,  // byte_valid
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata   // digest_part0, part1, part2, part3 from low bits
);
  import sha256_pkg::*;

  sha256_cmd_t  cmd;
  sha256_sts_t  sts;
  logic [255:0] digest;

  sha256_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(s_axis_tvalid && s_axis_tready),
    .in_valid_byte(s_axis_tuser),
    .in_last(s_axis_tlast),
    .in_ready(s_axis_tready),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .sts, .cmd
  );

  sha256_datapath u_dp (
    .clk, .rst, .cmd, .in_byte(s_axis_tdata), .sts, .digest
  );

  assign m_axis_tdata = {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};
endmodule

FILE: test/sha256_byte_stream_hasher_test.sv
// Self-checking regression for the SHA-256 byte stream hasher.
module sha256_byte_stream_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sha256_pkg::*;

  localparam int StallLimit = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // data_byte
  logic         s_axis_tlast = 1'b0; // last
  logic         s_axis_tuser = 1'b0; // byte_valid
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;        // digest_part0, part1, part2, part3 from low bits

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  int unsigned  block_count;
  logic [63:0]  bit_length;
  logic [255:0] digest_queue [$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           sent_words = 0;
  bit           quiet_mode = 1'b0;

  sha256_byte_stream_hasher u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) hash_state[i] = INITIAL_H[i];
    for (int i = 0; i < 64; i++) msg_block[i] = '0;
    block_count = 0;
    bit_length = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  // Advances the expected hash state by one accepted word.
  task automatic hash_accept(logic [7:0] data, logic valid, logic last);
    logic [255:0] digest;
    if (valid) begin
      msg_block[block_count] = data;
      block_count = (block_count + 1) % 64;
      bit_length += 64'd8;
      if (block_count == 0) compress();
    end
    if (last) begin
      msg_block[block_count] = PadByte;
      for (int i = block_count + 1; i < 64; i++) msg_block[i] = '0;
      if (block_count >= 56) begin
        compress();
        for (int i = 0; i < 56; i++) msg_block[i] = '0;
      end
      for (int i = 0; i < 8; i++) msg_block[63-i] = bit_length[8*i +: 8];
      compress();
      for (int i = 0; i < 4; i++)
        digest[64*i +: 64] = {hash_state[2*i], hash_state[2*i+1]};
      digest_queue = {digest_queue, digest};
      hash_reset();
    end
  endtask

  task automatic send_word(logic [7:0] data, logic valid, logic last);
    int gap;
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    hash_accept(data, valid, last);
    sent_words++;
  endtask

  task automatic send_message(int len, bit with_empty, bit final_byte);
    for (int i = 0; i < len; i++) begin
      if (with_empty && $urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == len - 1) && final_byte);
    end
    if (!final_byte || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, then every result checked in order.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_queue.size() == 0) begin
          $error("digest with no message pending: %h", m_axis_tdata);
          error_count++;
        end else begin
          for (int i = 0; i < 4; i++)
            if (m_axis_tdata[64*i +: 64] !== digest_queue[0][64*i +: 64]) begin
              $error("digest_part%0d expected %h actual %h", i,
                     digest_queue[0][64*i +: 64], m_axis_tdata[64*i +: 64]);
              error_count++;
            end
          void'(digest_queue.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("sha256_byte_stream_hasher regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(8'h00, 1'b0, 1'b1);            // empty message
    send_word(8'hff, 1'b0, 1'b0);            // empty word changes nothing
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);            // "abc"
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
  endtask

  // Lengths around the one-block and two-block padding boundaries.
  task automatic test_pad_boundaries();
    int lens [8] = '{55, 56, 57, 63, 64, 65, 119, 128};
    foreach (lens[i]) send_message(lens[i], 1'b0, 1'(lens[i] % 2));
  endtask

  task automatic test_random();
    int len;
    while (sent_words < 1350) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 140) : $urandom_range(0, 20);
      send_message(len, 1'b1, 1'($urandom_range(0, 1)));
      if (sent_words > 1100) quiet_mode = 1'b1;
    end
  endtask

  initial begin
    hash_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_pad_boundaries();
    wait_drained();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0 && digest_queue.size() == 0)
      $display("sha256_byte_stream_hasher regression: pass");
    else
      $display("sha256_byte_stream_hasher regression: fail");
    $finish;
  end
endmodule
